/* hw/rtl/csr_mse_pkg.sv */
// Shared types and constants for the masked CSR submatrix extract unit.
// Depends on nothing; every other file of the block but csr_mse_ram imports it.
package csr_mse_pkg;

  // Index space of the keep map and the renumber table.
  localparam int MAX_DIM = 1024;
  localparam int IDX_W   = 10;   // bits of one index into the tables
  localparam int CNT_W   = 11;   // index counters that can also hold MAX_DIM

  // Kept-entry counter; it stops at the largest row pointer that fits.
  localparam int ENTRY_W = 16;
  localparam logic [ENTRY_W-1:0] ENTRY_LIMIT = 16'hFFFF;

  localparam int VALUE_W = 64;

  // Result queue between the table stage and the output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  // Stream widths.
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 96;

  // Input commands.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_LOAD    = 2'd0;
  localparam cmd_t CMD_ENTRY   = 2'd1;
  localparam cmd_t CMD_ROW_END = 2'd2;

  // Result kinds.
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_PTR   = 1'b1;

  // One resolved result as it travels through the queue.
  typedef struct packed {
    logic               is_ptr;
    logic [IDX_W-1:0]   new_col;
    logic [VALUE_W-1:0] value;
  } op_t;

endpackage

/* hw/rtl/csr_mse_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module csr_mse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/csr_mse_front.sv */
// Front part: accepts input beats, keeps the load/row counters, writes and
// reads the keep tables, and resolves each item into a queued result.
// Depends on csr_mse_pkg and csr_mse_ram.
module csr_mse_front
  import csr_mse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmd_t               cmd,
  input  logic               keep,
  input  logic [IDX_W-1:0]   col,
  input  logic [VALUE_W-1:0] value,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               push,
  output op_t                push_op
);

  logic [CNT_W-1:0]   load_index;
  logic [CNT_W-1:0]   kept_count;
  logic [CNT_W-1:0]   current_row;

  logic               st_valid;
  logic               st_entry;
  logic               st_row_end;
  logic               st_row_ok;
  logic               st_col_ok;
  logic [VALUE_W-1:0] st_value;

  logic               accept;
  logic               load_ok;
  logic               tbl_we;
  logic [Q_CNT_W-1:0] credit_used;
  logic [IDX_W:0]     col_rd;
  logic [0:0]         row_rd;
  logic               col_keep;
  logic               row_keep;

  // A slot is reserved in the queue for the item now in the table stage.
  assign credit_used = q_count + Q_CNT_W'(st_valid);
  assign in_ready    = credit_used < Q_CNT_W'(Q_DEPTH);
  assign accept      = in_valid && in_ready;
  assign load_ok     = load_index < CNT_W'(MAX_DIM);
  assign tbl_we      = accept && (cmd == CMD_LOAD) && load_ok;

  // Column table: keep bit on top of the renumbered index.
  csr_mse_ram #(
    .WIDTH (IDX_W + 1),
    .DEPTH (MAX_DIM)
  ) u_col_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (load_index[IDX_W-1:0]),
    .wdata ({keep, kept_count[IDX_W-1:0]}),
    .re    (accept),
    .raddr (col),
    .rdata (col_rd)
  );

  // Row table: a second copy of the keep bits for the current row lookup.
  csr_mse_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DIM)
  ) u_row_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (load_index[IDX_W-1:0]),
    .wdata (keep),
    .re    (accept),
    .raddr (current_row[IDX_W-1:0]),
    .rdata (row_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index  <= '0;
      kept_count  <= '0;
      current_row <= '0;
      st_valid    <= 1'b0;
    end else begin
      st_valid <= accept && ((cmd == CMD_ENTRY) || (cmd == CMD_ROW_END));
      if (tbl_we) begin
        load_index <= load_index + 1'b1;
        kept_count <= kept_count + CNT_W'(keep);
      end
      if (accept && (cmd == CMD_ROW_END) && (current_row < CNT_W'(MAX_DIM))) begin
        current_row <= current_row + 1'b1;
      end
    end
  end

  // Range checks use the counters as they stand when the item is accepted.
  always_ff @(posedge clk) begin
    st_entry   <= (cmd == CMD_ENTRY);
    st_row_end <= (cmd == CMD_ROW_END);
    st_row_ok  <= current_row < load_index;
    st_col_ok  <= {1'b0, col} < load_index;
    st_value   <= value;
  end

  assign col_keep = col_rd[IDX_W];
  assign row_keep = row_rd[0];

  always_comb begin
    push = st_valid && st_row_ok && row_keep &&
           (st_row_end || (st_entry && st_col_ok && col_keep));
    push_op.is_ptr  = st_row_end;
    push_op.new_col = st_row_end ? '0 : col_rd[IDX_W-1:0];
    push_op.value   = st_row_end ? '0 : st_value;
  end

`ifndef SYNTH
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_index <= CNT_W'(MAX_DIM))
    else $error("load index ran past the table size");
  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    kept_count <= load_index)
    else $error("more kept indices than loaded indices");
  a_push_follows: assert property (@(posedge clk) disable iff (rst)
    push |-> $past(accept))
    else $error("result pushed without an item accepted the cycle before");
`endif

endmodule

/* hw/rtl/csr_mse_queue.sv */
// Short result queue between the front part and the output stage.
// Depends on csr_mse_pkg.
module csr_mse_queue
  import csr_mse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  op_t                push_op,
  input  logic               pop,
  output op_t                head,
  output logic [Q_CNT_W-1:0] count
);

  op_t                entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < Q_CNT_W'(Q_DEPTH)) || pop)
    else $error("push into a full result queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from an empty result queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone push");
`endif

endmodule

/* hw/rtl/csr_mse_back.sv */
// Back part: drains the result queue, keeps the kept-entry counter and
// holds the output register of the master stream.
// Depends on csr_mse_pkg.
module csr_mse_back
  import csr_mse_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [Q_CNT_W-1:0] q_count,
  input  op_t                head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [IDX_W-1:0]   new_col,
  output logic [VALUE_W-1:0] out_value_bits,
  output logic [ENTRY_W-1:0] row_pointer
);

  logic [ENTRY_W-1:0] entry_count;

  assign pop = (q_count != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      entry_count <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (!head.is_ptr && (entry_count < ENTRY_LIMIT)) begin
          entry_count <= entry_count + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pointer beats report the count of entries popped before them.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind           <= head.is_ptr ? KIND_PTR : KIND_ENTRY;
      new_col        <= head.new_col;
      out_value_bits <= head.value;
      row_pointer    <= head.is_ptr ? entry_count : '0;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= ENTRY_LIMIT)
    else $error("kept-entry counter beyond its limit");
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (pop && head.is_ptr) |=> $stable(entry_count))
    else $error("kept-entry counter moved on a row pointer");
  a_pop_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop)
    else $error("output register overwritten while stalled");
`endif

endmodule

/* hw/rtl/csr_masked_submatrix_extract_unit.sv */
// Top level of the masked CSR submatrix extract unit.
// Depends on csr_mse_pkg, csr_mse_front, csr_mse_queue and csr_mse_back.

// This unit cuts a principal submatrix out of a compressed sparse row stream.
// Keep bits are loaded first (command load, one index per beat, up to 1024
// indices); each kept index is renumbered to the count of kept indices before
// it. Nonzero beats (command entry) are then passed on with their renumbered
// column when both the current source row and the column are kept, and each
// end-of-row beat of a kept row emits the running count of kept entries as
// the next row pointer; the leading zero pointer is not sent. Rows and columns
// at or beyond the loaded size count as dropped, and the pointer count stops
// at 65535. The unit takes one input beat per clock while the result queue has
// room and gives one result beat per clock while the output side is ready: an
// accepted item passes the table stage, where both keep tables are read from
// registered-read RAMs, and then enters a four-entry result queue ahead of the
// output register. The input stays ready as
// long as the queue has room for every item already in flight, which keeps
// the full rate when the output side takes a beat each cycle. No clearing
// pass is needed after reset: table outputs are only used below the loaded size.
module csr_masked_submatrix_extract_unit
  import csr_mse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // keep, col[9:0], value_bits[63:0], zero pad
  input  logic [1:0]            s_tuser,   // cmd[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // new_col[9:0], out_value_bits[63:0],
                                           // row_pointer[15:0], zero pad
  output logic [0:0]            m_tuser    // kind
);

  logic               push;
  op_t                push_op;
  logic               pop;
  op_t                head;
  logic [Q_CNT_W-1:0] q_count;

  logic               kind;
  logic [IDX_W-1:0]   new_col;
  logic [VALUE_W-1:0] out_value_bits;
  logic [ENTRY_W-1:0] row_pointer;

  csr_mse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (s_tuser),
    .keep     (s_tdata[0]),
    .col      (s_tdata[IDX_W:1]),
    .value    (s_tdata[IDX_W+VALUE_W:IDX_W+1]),
    .q_count  (q_count),
    .push     (push),
    .push_op  (push_op)
  );

  csr_mse_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .count   (q_count)
  );

  csr_mse_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_count        (q_count),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .kind           (kind),
    .new_col        (new_col),
    .out_value_bits (out_value_bits),
    .row_pointer    (row_pointer)
  );

  // Result fields packed from the lowest bit up; the top bits are zero.
  assign m_tdata = {{(OUT_DATA_W - IDX_W - VALUE_W - ENTRY_W){1'b0}},
                    row_pointer, out_value_bits, new_col};
  assign m_tuser = kind;

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue holds more than its depth");
  a_ptr_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (kind == KIND_PTR)) |-> (new_col == '0) && (out_value_bits == '0))
    else $error("row pointer beat carries entry fields");
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> q_count < Q_CNT_W'(Q_DEPTH))
    else $error("input ready with no room left in the result queue");
`endif

endmodule

/* verif/csr_mse_result_checker.sv */
// Checker for the masked CSR submatrix extract unit: predicts each result from the
// input beats it observes and compares it with the output stream. Depends on csr_mse_pkg.
`timescale 1ns / 100ps

module csr_mse_result_checker
  import csr_mse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // keep, col[9:0], value_bits[63:0], zero pad
  input  logic [1:0]            s_tuser,   // cmd[1:0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // new_col[9:0], out_value_bits[63:0],
                                           // row_pointer[15:0], zero pad
  input  logic [0:0]            m_tuser,   // kind
  output int                    errors,
  output int                    outstanding,
  output int                    beats_in,
  output int                    results_seen,
  output int                    ptrs_seen
);

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   new_col;
    logic [VALUE_W-1:0] value;
    logic [ENTRY_W-1:0] row_ptr;
  } result_t;

  // Mirror of the unit's tables and counters.
  logic               keep_map [MAX_DIM];
  logic [IDX_W-1:0]   renum    [MAX_DIM];
  logic [CNT_W-1:0]   loaded;
  logic [CNT_W-1:0]   kept;
  logic [CNT_W-1:0]   row;
  logic [ENTRY_W-1:0] emitted;

  result_t pending_q[$];

  // An index counts as kept only below the loaded size, so unwritten entries are never read.
  function automatic bit index_kept(input logic [CNT_W-1:0] idx);
    return (idx < loaded) && keep_map[idx[IDX_W-1:0]];
  endfunction

  task automatic extract_step(input cmd_t c, input logic k, input logic [IDX_W-1:0] cl,
                              input logic [VALUE_W-1:0] v, output bit hit, output result_t r);
    bit row_kept;
    hit = 1'b0;
    r   = '0;
    case (c)
      CMD_LOAD: begin
        if (loaded < MAX_DIM) begin
          keep_map[loaded[IDX_W-1:0]] = k;
          renum[loaded[IDX_W-1:0]]    = kept[IDX_W-1:0];
          kept   = kept + k;
          loaded = loaded + 1'b1;
        end
      end
      CMD_ENTRY: begin
        if (index_kept(row) && index_kept({1'b0, cl})) begin
          hit       = 1'b1;
          r.kind    = KIND_ENTRY;
          r.new_col = renum[cl];
          r.value   = v;
          if (emitted < ENTRY_LIMIT) emitted = emitted + 1'b1;
        end
      end
      CMD_ROW_END: begin
        row_kept = index_kept(row);
        if (row < MAX_DIM) row = row + 1'b1;
        if (row_kept) begin
          hit       = 1'b1;
          r.kind    = KIND_PTR;
          r.row_ptr = emitted;
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic int field_diff(input string name, input logic [VALUE_W-1:0] want,
                                    input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    result_t r;
    bit      hit;
    int      bad;
    int      delta;
    if (rst) begin
      loaded  = '0;
      kept    = '0;
      row     = '0;
      emitted = '0;
      pending_q.delete();
      errors       <= 0;
      outstanding  <= 0;
      beats_in     <= 0;
      results_seen <= 0;
      ptrs_seen    <= 0;
    end else begin
      bad   = 0;
      delta = 0;
      // The output side is handled first, so a result can never match an expectation
      // that is only being created in the same cycle.
      if (m_tvalid && m_tready) begin
        got.kind    = m_tuser[0];
        got.new_col = m_tdata[IDX_W-1:0];
        got.value   = m_tdata[IDX_W+VALUE_W-1:IDX_W];
        got.row_ptr = m_tdata[IDX_W+VALUE_W+ENTRY_W-1:IDX_W+VALUE_W];
        if (pending_q.size() == 0) begin
          $error("result beat with no expectation waiting: kind %0d", got.kind);
          bad = bad + 1;
        end else begin
          want  = pending_q.pop_front();
          delta = delta - 1;
          bad = bad + field_diff("kind", want.kind, got.kind);
          bad = bad + field_diff("new_col", want.new_col, got.new_col);
          bad = bad + field_diff("out_value_bits", want.value, got.value);
          bad = bad + field_diff("row_pointer", want.row_ptr, got.row_ptr);
        end
        results_seen <= results_seen + 1;
        if (got.kind == KIND_PTR) ptrs_seen <= ptrs_seen + 1;
      end
      if (s_tvalid && s_tready) begin
        extract_step(cmd_t'(s_tuser), s_tdata[0], s_tdata[IDX_W:1],
                     s_tdata[IDX_W+VALUE_W:IDX_W+1], hit, r);
        if (hit) begin
          pending_q.push_back(r);
          delta = delta + 1;
        end
        beats_in <= beats_in + 1;
      end
      errors      <= errors + bad;
      outstanding <= outstanding + delta;
    end
  end

endmodule

/* verif/csr_masked_submatrix_extract_unit_test.sv */
// Top of the masked CSR submatrix extract testbench: clock, reset, stimulus and verdict.
// Depends on csr_mse_pkg, the unit under test and csr_mse_result_checker.
`timescale 1ns / 100ps

module csr_masked_submatrix_extract_unit_test;
  import csr_mse_pkg::*;

  // The unit ignores the fourth command code; it is sent now and then as noise.
  localparam cmd_t CMD_NONE = 2'd3;

  localparam int CYCLE_LIMIT = 5000000;

  // Hold-off on the result side once enough results have flowed.
  localparam int HOLD_AFTER  = 120;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_t;

  logic                  clk;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // keep, col[9:0], value_bits[63:0], zero pad
  logic [1:0]            s_tuser  = CMD_LOAD;   // cmd[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // new_col[9:0], out_value_bits[63:0],
                                         // row_pointer[15:0], zero pad
  logic [0:0]            m_tuser;        // kind

  int errors;
  int outstanding;
  int beats_in;
  int results_seen;
  int ptrs_seen;

  csr_masked_submatrix_extract_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  csr_mse_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .errors       (errors),
    .outstanding  (outstanding),
    .beats_in     (beats_in),
    .results_seen (results_seen),
    .ptrs_seen    (ptrs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A stuck handshake ends the run here.
  int cycles;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results still expected", cycles, outstanding);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side. It cycles through stall styles of random length: always ready, a coin
  // toss per cycle, one beat in four, and a fixed five-of-eight pattern. Once, after
  // 120 results, it holds off for a long stretch so the result queue fills up and
  // the unit has to drop its input ready while beats keep being offered.
  rx_style_t rx_style;
  int        style_left;
  int        hold_left;
  bit        held;
  logic [2:0] rx_phase;
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      rx_style   <= RX_OPEN;
      style_left <= 0;
      hold_left  <= 0;
      held       <= 1'b0;
      rx_phase   <= '0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && results_seen >= HOLD_AFTER) begin
      m_tready  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      held      <= 1'b1;
    end else begin
      if (style_left == 0) begin
        rx_style   <= rx_style_t'($urandom_range(0, 3));
        style_left <= $urandom_range(32, 512);
      end else begin
        style_left <= style_left - 1;
      end
      rx_phase <= rx_phase + 1'b1;
      case (rx_style)
        RX_OPEN:    m_tready <= 1'b1;
        RX_COIN:    m_tready <= $urandom_range(0, 1);
        RX_SPARSE:  m_tready <= ($urandom_range(0, 3) == 0);
        RX_PATTERN: m_tready <= (rx_phase < 3'd5);
        default:    m_tready <= 1'b1;
      endcase
    end
  end

  // Stimulus bookkeeping: what has been sent, not what the unit computes.
  int n_loaded;
  int n_rows;
  int useful;
  int burst_left;

  // Offers one beat and returns at the edge where it was taken. Beats go out in bursts
  // of random length; between most bursts tvalid drops for a random gap.
  task automatic put_beat(input cmd_t c, input logic k, input logic [IDX_W-1:0] cl,
                          input logic [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {5'b0, v, cl, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left = burst_left - 1;
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // Unused fields of a beat carry random bits so that every input bit but the zero pad toggles.
  task automatic load_bit(input logic k);
    put_beat(CMD_LOAD, k, $urandom_range(0, 1023), rand_value());
    if (n_loaded < MAX_DIM) begin
      useful = useful + 1;
    end
    n_loaded = n_loaded + 1;
  endtask

  task automatic send_entry(input logic [IDX_W-1:0] cl, input logic [VALUE_W-1:0] v);
    put_beat(CMD_ENTRY, $urandom_range(0, 1), cl, v);
    useful = useful + 1;
  endtask

  task automatic send_row_end();
    put_beat(CMD_ROW_END, $urandom_range(0, 1), $urandom_range(0, 1023), rand_value());
    n_rows = n_rows + 1;
    useful = useful + 1;
  endtask

  // Stops offering and waits until every expected result has come out. Status from
  // the checker is read on the falling edge, where it is settled.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : stimulus
    int                 n;
    int                 hi;
    int                 density;
    bit                 paused;
    logic [IDX_W-1:0]   cl;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Before anything is loaded, every row and column is out of range.
    send_entry(10'h3FF, '1);
    put_beat(CMD_NONE, 1'b1, 10'h3FF, '1);
    // Indices 0, 2 and 3 are kept and renumbered to 0, 1 and 2; index 1 is dropped.
    load_bit(1'b1);
    load_bit(1'b0);
    load_bit(1'b1);
    load_bit(1'b1);
    // Row 0 is kept: columns 0, 2 and 3 pass, column 1 is dropped and columns 4 and
    // 1023 lie beyond the loaded size.
    send_entry(10'd0, '1);
    send_entry(10'd1, rand_value());
    send_entry(10'd2, '0);
    send_entry(10'd3, 64'h8000_0000_0000_0001);
    send_entry(10'd4, rand_value());
    send_entry(10'h3FF, rand_value());
    send_row_end();
    // Row 1 is dropped, entry and end alike.
    send_entry(10'd0, rand_value());
    send_row_end();
    // Loading between rows extends the size: column 4 becomes valid for row 2.
    load_bit(1'b1);
    send_entry(10'd4, '1);
    send_row_end();
    // Rows 3 and 4 are kept but empty, so each repeats the last pointer.
    send_row_end();
    send_row_end();
    // Row 5 is past the loaded size.
    send_entry(10'd0, rand_value());
    send_row_end();
    drain_results();

    // Random part: keep bits arrive in bursts of random density, interleaved with rows
    // that are mostly well formed, plus out-of-range columns and unused commands.
    paused = 1'b0;
    while (useful < 600) begin
      if (n_loaded < MAX_DIM + 8 && $urandom_range(0, 1) == 0) begin
        density = $urandom_range(30, 95);
        repeat ($urandom_range(1, 24)) load_bit($urandom_range(0, 99) < density);
      end else begin
        n  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
        hi = (n_loaded > MAX_DIM) ? MAX_DIM - 1 : n_loaded - 1;
        repeat (n) begin
          if ($urandom_range(0, 29) == 0)
            put_beat(CMD_NONE, $urandom_range(0, 1), $urandom_range(0, 1023), rand_value());
          cl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, hi);
          send_entry(cl, rand_value());
        end
        send_row_end();
      end
      if (!paused && useful >= 300) begin
        drain_results();
        paused = 1'b1;
      end
    end

    // Fill the keep map to capacity and send a few more bits, which are ignored.
    while (n_loaded < MAX_DIM + 4) load_bit($urandom_range(0, 3) != 0);

    // Run the row counter up to its limit and past it, with occasional entries.
    while (n_rows < MAX_DIM + 6) begin
      if ($urandom_range(0, 7) == 0) send_entry($urandom_range(0, 1023), rand_value());
      send_row_end();
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("Summary: %0d input beats, %0d results checked, %0d of them row pointers.",
             beats_in, results_seen, ptrs_seen);
    $display("Keep map loaded past capacity, rows run past the row limit, %s",
             "out-of-range columns, unused commands and a long output stall.");
    if (errors == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
